// ----- hw/rtl/sfcd_pkg.sv -----
package sfcd_pkg;

  // check code: polynomial, start value, top bit
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  // byte positions within a frame
  typedef logic [2:0] pos_t;
  localparam pos_t POS_FIRST = 3'd0;
  localparam pos_t POS_CHK1  = 3'd2;
  localparam pos_t POS_CHK2  = 3'd5;
  localparam pos_t POS_LAST  = 3'd5;

  // frame kinds
  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_ID   = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_BAD1 = 2'd1;
  localparam status_t ST_BAD2 = 2'd2;

  // fixed point scaling: value = (raw * scale) >> 16, minus offset
  localparam int TEMP_SCALE  = 17500;
  localparam int TEMP_OFFSET = 4500;
  localparam int HUM_SCALE   = 10000;
  localparam int HUM_MAX     = 9999;
  localparam int TEMP_MIN    = -4500;

  // one finished frame, handed from the byte tracker to the scaler
  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [15:0] word1;
    logic [15:0] word2;
  } frame_res_t;

  // one byte of crc-8, msb first, no final xor
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/sfcd_if.sv -----
// received byte channel
interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       frame_start;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output frame_start, output rx_byte,
                  input ready);
  modport sink (input valid, input mode, input frame_start, input rx_byte,
                output ready);
endinterface

// decoded frame result channel
interface sfcd_out_if;
  logic               valid;
  logic               ready;
  logic               frame_kind;
  logic [1:0]         status;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;
  logic [15:0]        device_id;

  modport source (output valid, output frame_kind, output status, output temp_centi,
                  output hum_centi, output device_id, input ready);
  modport sink (input valid, input frame_kind, input status, input temp_centi,
                input hum_centi, input device_id, output ready);
endinterface

// ----- hw/rtl/sfcd_frame.sv -----
module sfcd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic                frame_start,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  input  logic                res_ready,
  output sfcd_pkg::frame_res_t res
);
  import sfcd_pkg::*;

  pos_t        pos_r, pos_nxt, pos_cur, pos_inc;
  logic [7:0]  crc_r, crc_nxt, crc_cur;
  logic        kind_r, kind_cur;
  status_t     err_r, err_nxt, err_cur;
  logic [15:0] wbuf_r, wbuf_nxt, wbuf_cur;
  logic [15:0] word1_r, word1_nxt;
  logic        res_valid_r, res_valid_nxt;
  frame_res_t  res_r, res_nxt;
  logic        accept, first, is_chk, done;

  assign in_ready = !res_valid_r || res_ready;
  assign accept   = in_valid && in_ready;

  // frame start or position zero opens a fresh frame
  assign pos_cur  = frame_start ? POS_FIRST : pos_r;
  assign first    = (pos_cur == POS_FIRST);
  assign kind_cur = first ? mode : kind_r;
  assign crc_cur  = first ? CRC_INIT : crc_r;
  assign err_cur  = first ? ST_OK : err_r;
  assign wbuf_cur = first ? 16'h0000 : wbuf_r;
  assign is_chk   = (pos_cur == POS_CHK1) || (pos_cur == POS_CHK2);
  assign done     = (pos_cur == POS_CHK2) || ((pos_cur == POS_CHK1) && (kind_cur == KIND_ID));
  assign pos_inc  = pos_cur + 3'd1;

  // check byte compares, data byte shifts into the word and the crc
  always_comb begin
    crc_nxt   = crc_cur;
    err_nxt   = err_cur;
    wbuf_nxt  = wbuf_cur;
    word1_nxt = word1_r;
    if (is_chk) begin
      crc_nxt = CRC_INIT;
      if ((crc_cur != rx_byte) && (err_cur == ST_OK)) begin
        err_nxt = (pos_cur == POS_CHK1) ? ST_BAD1 : ST_BAD2;
      end
      if (pos_cur == POS_CHK1) begin
        word1_nxt = wbuf_cur;
      end
    end else begin
      crc_nxt  = crc_byte(crc_cur, rx_byte);
      wbuf_nxt = {wbuf_cur[7:0], rx_byte};
    end
  end

  // next byte position
  always_comb begin
    if (done || (pos_inc > POS_LAST)) begin
      pos_nxt = POS_FIRST;
    end else begin
      pos_nxt = pos_inc;
    end
  end

  // finished frame beat
  always_comb begin
    res_nxt.kind   = kind_cur;
    res_nxt.status = err_nxt;
    res_nxt.word1  = word1_nxt;
    res_nxt.word2  = wbuf_cur;
  end

  always_comb begin
    if (accept && done) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_FIRST;
      crc_r       <= CRC_INIT;
      kind_r      <= KIND_MEAS;
      err_r       <= ST_OK;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (accept) begin
        pos_r  <= pos_nxt;
        crc_r  <= crc_nxt;
        kind_r <= kind_cur;
        err_r  <= err_nxt;
      end
    end
  end

  // data words and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      wbuf_r  <= wbuf_nxt;
      word1_r <= word1_nxt;
      if (done) begin
        res_r <= res_nxt;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ----- hw/rtl/sfcd_conv.sv -----
module sfcd_conv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  sfcd_pkg::frame_res_t res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 frame_kind,
  output logic [1:0]           status,
  output logic signed [14:0]   temp_centi,
  output logic [13:0]          hum_centi,
  output logic [15:0]          device_id
);
  import sfcd_pkg::*;

  logic        out_valid_r;
  logic        kind_r;
  status_t     status_r;
  logic [14:0] temp_r, temp_nxt;
  logic [13:0] hum_r, hum_nxt;
  logic [15:0] id_r, id_nxt;
  logic [30:0] temp_prod;
  logic [29:0] hum_prod;
  logic        load, ok;

  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;
  assign ok        = (res.status == ST_OK);

  // constant scaling of the raw words
  assign temp_prod = {15'd0, res.word1} * 31'(TEMP_SCALE);
  assign hum_prod  = {14'd0, res.word2} * 30'(HUM_SCALE);

  // fields that do not belong to the frame kind, or a bad check, read zero
  always_comb begin
    temp_nxt = '0;
    hum_nxt  = '0;
    id_nxt   = '0;
    if (ok) begin
      if (res.kind == KIND_ID) begin
        id_nxt = res.word1;
      end else begin
        temp_nxt = temp_prod[30:16] - 15'(TEMP_OFFSET);
        hum_nxt  = hum_prod[29:16];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= res.kind;
      status_r <= res.status;
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
      id_r     <= id_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign frame_kind = kind_r;
  assign status     = status_r;
  assign temp_centi = $signed(temp_r);
  assign hum_centi  = hum_r;
  assign device_id  = id_r;

endmodule

// ----- hw/rtl/sensor_frame_crc_decoder.sv -----
// Sensor frame decoder: takes one received byte per cycle, checks each two-byte
// word against its crc-8 byte (poly 0x31, init 0xff) and gives one result beat
// per finished frame (six bytes for a measurement, three for an identifier).
// A byte is taken every cycle as long as the result side keeps up; the only
// thing that holds bytes back is a stalled result register. The result beat
// of a frame is registered first in the byte tracker's frame register and then
// in the scaling stage's output register.
// frame_start forces the byte to begin a new frame and drops any partial frame.
module sensor_frame_crc_decoder (
  input  logic              clk,
  input  logic              rst_n,
  sfcd_in_if.sink           in_bus,
  sfcd_out_if.source        out_bus
);
  import sfcd_pkg::*;

  logic       frm_valid;
  logic       frm_ready;
  frame_res_t frm;

  // byte position, crc and word tracking
  sfcd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .mode        (in_bus.mode),
    .frame_start (in_bus.frame_start),
    .rx_byte     (in_bus.rx_byte),
    .res_valid   (frm_valid),
    .res_ready   (frm_ready),
    .res         (frm)
  );

  // unit scaling and result register
  sfcd_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (frm_valid),
    .res_ready  (frm_ready),
    .res        (frm),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .frame_kind (out_bus.frame_kind),
    .status     (out_bus.status),
    .temp_centi (out_bus.temp_centi),
    .hum_centi  (out_bus.hum_centi),
    .device_id  (out_bus.device_id)
  );

endmodule

// ----- hw/rtl/sfcd_checker.sv -----
module sfcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               frame_kind,
  input logic [1:0]         status,
  input logic signed [14:0] temp_centi,
  input logic [13:0]        hum_centi,
  input logic [15:0]        device_id
);
  import sfcd_pkg::*;

  // a stalled result beat stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(status) && $stable(temp_centi)
      && $stable(hum_centi) && $stable(device_id) && $stable(frame_kind))
    else $error("result payload changed while stalled");

  // a failed check zeroes every value field
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |->
      (temp_centi == 15'sd0) && (hum_centi == 14'd0) && (device_id == 16'd0))
    else $error("values not zero on failed check");

  // identifier results carry no measurement, measurements stay in range
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OK) |->
      ((frame_kind == KIND_ID) && (temp_centi == 15'sd0) && (hum_centi == 14'd0))
      || ((frame_kind == KIND_MEAS) && (device_id == 16'd0)
          && (hum_centi <= 14'(HUM_MAX)) && (temp_centi >= 15'(TEMP_MIN))))
    else $error("result fields do not match frame kind");

endmodule

bind sensor_frame_crc_decoder sfcd_checker u_sfcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .frame_kind (out_bus.frame_kind),
  .status     (out_bus.status),
  .temp_centi (out_bus.temp_centi),
  .hum_centi  (out_bus.hum_centi),
  .device_id  (out_bus.device_id)
);

// ----- dv/sensor_frame_crc_decoder_test.sv -----
`timescale 1ns / 1ps

module sensor_frame_crc_decoder_test;
  import sfcd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BYTES = 1200;

  // one byte beat waiting to be sent; drain makes the sender wait for all results
  typedef struct {
    logic       mode;
    logic       start;
    logic [7:0] data;
    logic       drain;
  } byte_beat_t;

  // one decoded frame result
  typedef struct {
    logic               kind;
    status_t            status;
    logic signed [14:0] temp;
    logic [13:0]        hum;
    logic [15:0]        id;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sfcd_in_if  in_ch ();
  sfcd_out_if out_ch ();

  sensor_frame_crc_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_beat_t    byte_q[$];
  frame_result_t frame_q[$];
  frame_result_t want;

  // predicted decoder state
  pos_t        trk_pos;
  logic [7:0]  trk_crc;
  logic        trk_kind;
  logic [15:0] trk_word;
  logic [15:0] trk_first;
  status_t     trk_err;

  int  cycles;
  int  n_errors;
  int  n_bytes;
  int  n_results;
  int  n_good;
  int  n_ids;
  int  send_idle;
  int  recv_stall;
  logic drain_next;

  // idle-free stretches come and go with the cycle count
  function automatic int pick_gap();
    int r;
    if (((cycles / 1500) % 4) == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // crc-8 of one byte, msb first
  function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  function automatic logic [7:0] word_crc(logic [15:0] w);
    return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // track one accepted byte and queue the result of a finished frame
  function automatic void decode_byte(logic mode, logic start, logic [7:0] b);
    pos_t          p;
    logic          done;
    frame_result_t r;
    int            t;
    int            h;
    if (start) trk_pos = POS_FIRST;
    p = trk_pos;
    done = 1'b0;
    if (p == POS_FIRST) begin
      trk_kind = mode;
      trk_crc  = CRC_INIT;
      trk_err  = ST_OK;
      trk_word = 16'h0000;
    end
    if (p == POS_CHK1 || p == POS_CHK2) begin
      if (trk_crc != b && trk_err == ST_OK) trk_err = (p == POS_CHK1) ? ST_BAD1 : ST_BAD2;
      trk_crc = CRC_INIT;
      if (p == POS_CHK1) begin
        trk_first = trk_word;
        done = (trk_kind == KIND_ID);
      end else begin
        done = 1'b1;
      end
    end else begin
      trk_crc  = crc8_step(trk_crc, b);
      trk_word = {trk_word[7:0], b};
    end
    if (!done) begin
      trk_pos = (p >= POS_LAST) ? POS_FIRST : pos_t'(p + 3'd1);
    end else begin
      trk_pos  = POS_FIRST;
      r.kind   = trk_kind;
      r.status = trk_err;
      r.temp   = '0;
      r.hum    = '0;
      r.id     = '0;
      if (trk_err == ST_OK) begin
        if (trk_kind == KIND_ID) begin
          r.id = trk_first;
        end else begin
          t = ((int'(trk_first) * TEMP_SCALE) >>> 16) - TEMP_OFFSET;
          h = (int'(trk_word) * HUM_SCALE) >>> 16;
          r.temp = t[14:0];
          r.hum  = h[13:0];
        end
      end
      frame_q.push_back(r);
    end
  endfunction

  function automatic void add_byte(logic mode, logic start, logic [7:0] data);
    byte_beat_t bt;
    bt.mode  = mode;
    bt.start = start;
    bt.data  = data;
    bt.drain = drain_next;
    drain_next = 1'b0;
    byte_q.push_back(bt);
  endfunction

  // queue the first keep bytes of a frame; flips corrupt the check bytes,
  // twist inverts mode after the first byte
  function automatic void add_frame(logic kind, logic [15:0] w1, logic [15:0] w2,
                                    logic start, logic [7:0] flip1, logic [7:0] flip2,
                                    logic twist, int keep);
    logic [7:0] seq [6];
    int         len;
    seq[0] = w1[15:8];
    seq[1] = w1[7:0];
    seq[2] = word_crc(w1) ^ flip1;
    seq[3] = w2[15:8];
    seq[4] = w2[7:0];
    seq[5] = word_crc(w2) ^ flip2;
    len = (kind == KIND_ID) ? 3 : 6;
    for (int i = 0; i < len && i < keep; i++) begin
      if (i == 0) add_byte(kind, start, seq[i]);
      else add_byte(twist ? ~kind : kind, 1'b0, seq[i]);
    end
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // sender: one beat in flight, random gaps, optional wait for all results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_idle   <= 0;
      trk_pos   = POS_FIRST;
      trk_crc   = CRC_INIT;
      trk_kind  = KIND_MEAS;
      trk_word  = 16'h0000;
      trk_first = 16'h0000;
      trk_err   = ST_OK;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.mode, in_ch.frame_start, in_ch.rx_byte);
        n_bytes++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_idle > 0) begin
          in_ch.valid <= 1'b0;
          send_idle   <= send_idle - 1;
        end else if (byte_q.size() > 0 && !(byte_q[0].drain && frame_q.size() != 0)) begin
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= byte_q[0].mode;
          in_ch.frame_start <= byte_q[0].start;
          in_ch.rx_byte     <= byte_q[0].data;
          void'(byte_q.pop_front());
          send_idle <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: kind=%0d status=%0d temp=%0d hum=%0d id=%04h",
                   $time, out_ch.frame_kind, out_ch.status, out_ch.temp_centi,
                   out_ch.hum_centi, out_ch.device_id);
        end else begin
          want = frame_q.pop_front();
          n_results++;
          if (want.status == ST_OK) n_good++;
          if (want.kind == KIND_ID) n_ids++;
          if (out_ch.frame_kind !== want.kind || out_ch.status !== want.status ||
              out_ch.temp_centi !== want.temp || out_ch.hum_centi !== want.hum ||
              out_ch.device_id !== want.id) begin
            n_errors++;
            $display("%0t: result mismatch: expected kind=%0d status=%0d temp=%0d hum=%0d id=%04h, got kind=%0d status=%0d temp=%0d hum=%0d id=%04h",
                     $time, want.kind, want.status, want.temp, want.hum, want.id,
                     out_ch.frame_kind, out_ch.status, out_ch.temp_centi,
                     out_ch.hum_centi, out_ch.device_id);
          end
        end
      end
      if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall   <= recv_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if ((out_ch.valid && out_ch.ready) || $urandom_range(0, 19) == 0)
          recv_stall <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, frame_q.size());
      $display("sensor_frame_crc_decoder_test NOT OK");
      $finish;
    end
  end

  initial begin
    int directed_n;
    int pick;
    int keep;
    logic kind;
    logic drain_mid;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = 1'b0;
    in_ch.frame_start = 1'b0;
    in_ch.rx_byte     = 8'h00;
    out_ch.ready      = 1'b0;
    cycles     = 0;
    n_errors   = 0;
    n_bytes    = 0;
    n_results  = 0;
    n_good     = 0;
    n_ids      = 0;
    drain_next = 1'b0;
    drain_mid  = 1'b0;

    // directed: temperature and humidity extremes, frame after a finished
    // frame without start flag plus mode flipping mid-frame, partial frame
    // dropped by a new start, identifier frame, second and both words bad
    add_frame(KIND_MEAS, 16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00, 1'b0, 6);
    add_frame(KIND_MEAS, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b1, 6);
    add_frame(KIND_MEAS, 16'h1234, 16'h5678, 1'b1, 8'h00, 8'h00, 1'b0, 1);
    add_frame(KIND_ID,   16'hFFFF, 16'h0000, 1'b1, 8'h00, 8'h00, 1'b1, 3);
    add_frame(KIND_MEAS, 16'h6666, 16'h8000, 1'b1, 8'h00, 8'h01, 1'b0, 6);
    add_frame(KIND_MEAS, 16'hBEEF, 16'h0001, 1'b0, 8'h80, 8'hFF, 1'b0, 6);
    directed_n = byte_q.size();

    // random: mostly well-formed frames, some corrupt, truncated or noise
    drain_next = 1'b1;
    while (byte_q.size() < directed_n + RANDOM_BYTES) begin
      if (!drain_mid && byte_q.size() >= directed_n + RANDOM_BYTES / 2) begin
        drain_mid  = 1'b1;
        drain_next = 1'b1;
      end
      pick = $urandom_range(0, 99);
      kind = 1'($urandom_range(0, 1));
      if (pick < 80) begin
        add_frame(kind, pick_word(), pick_word(), $urandom_range(0, 9) != 0,
                  ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                  ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                  1'($urandom_range(0, 1)), 6);
      end else if (pick < 90) begin
        keep = $urandom_range(1, (kind == KIND_ID) ? 2 : 5);
        add_frame(kind, pick_word(), pick_word(), 1'b1, 8'h00, 8'h00,
                  1'($urandom_range(0, 1)), keep);
      end else begin
        repeat ($urandom_range(1, 4))
          add_byte(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                   8'($urandom_range(0, 255)));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes, %0d frame results (%0d identifier, %0d with good checks)",
             n_bytes, n_results, n_ids, n_good);
    $display("including corrupt checks, dropped partial frames, mode flips and back-pressure");
    if (n_errors == 0) begin
      $display("sensor_frame_crc_decoder_test OK");
    end else begin
      $display("sensor_frame_crc_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
